[rtl/core/esp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect slot pool package
// Shared field widths, command codes, slot record types and constant tables
// for the effect slot pool with frame timers.
// ----------------------------------------------------------------------------
package esp_pkg;

   // Field widths of the request, response and register beats.
   localparam int KIND_W    = 3;
   localparam int EFFECT_W  = 3;
   localparam int SLOTIDX_W = 4;
   localparam int FRAME_W   = 8;
   localparam int PARTS_W   = 6;
   localparam int LEN_W     = 8;
   localparam int CSR_IDX_W = 3;

   // Number of effect length registers (effect types 1 to 7).
   localparam int NUM_LEN = 7;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMIT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

   // Slot write operations issued by the controller.
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_TICK = 2'd1;
   localparam logic [1:0] WR_MOD  = 2'd2;
   localparam logic [1:0] WR_SLOT = 2'd3;

   // Result staging operations issued by the controller.
   localparam logic [1:0] RES_KEEP = 2'd0;
   localparam logic [1:0] RES_ZERO = 2'd1;
   localparam logic [1:0] RES_EMIT = 2'd2;
   localparam logic [1:0] RES_SLOT = 2'd3;

   // Part counts per effect type; type 0 is unused.
   localparam logic [PARTS_W-1:0] PART_TABLE [8] = '{
      6'd0, 6'd15, 6'd20, 6'd25, 6'd20, 6'd40, 6'd30, 6'd40
   };

   // Length register values after reset.
   localparam logic [LEN_W-1:0] LEN_RESET [NUM_LEN] = '{
      8'd10, 8'd80, 8'd80, 8'd50, 8'd90, 8'd120, 8'd90
   };

   // One slot record as held in the slot memory.
   typedef struct packed {
      logic [EFFECT_W-1:0] effect;
      logic [FRAME_W-1:0]  frame;
      logic [PARTS_W-1:0]  parts;
      logic                looping;
      logic                playing;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   // One response beat.
   typedef struct packed {
      logic                 granted;
      logic [SLOTIDX_W-1:0] slot;
      slot_type             entry;
   } res_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       cap_req;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       rd_en;
      logic       rd_req;
      logic       mod_start;
      logic [1:0] wr_op;
      logic       emit_wr;
      logic [1:0] res_op;
      logic       out_ld;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;
      logic cur_free;
      logic need_mod;
      logic mod_done;
   } sts_type;

endpackage

[rtl/core/effect_slot_pool_timers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect slot pool with frame timers
// Allocates effect slots, starts and stops them, reports them and advances
// their frame timers on each tick.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel (kind, effect type, repeat, slot index)
// and each request gives exactly one response beat on the rsp_ channel.
// A beat moves when valid is high and stall is low.
// An emit walks the busy flags from slot 0 upward and takes the lowest free
// slot; a full pool gives a beat with no grant. The tick sweep reads one slot
// of the slot memory per cycle and writes the slot read before it on the same
// cycle; it pauses for each slot whose frame lies at or past its effect's
// length after that length was lowered, until the remainder unit has reduced
// that frame.
// One request is worked on at a time; req_stall is low only while idle.
// A response waiting under rsp_stall is held in the response register while
// the next request is already taken; that request finishes once the register
// has drained. Reset clears every slot to free and reloads the effect
// lengths. The length registers are to be written through csr_ only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module effect_slot_pool_timers #(
   parameter int SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [esp_pkg::KIND_W-1:0]         req_kind,
   input  logic [esp_pkg::EFFECT_W-1:0]       req_effect_type,
   input  logic                               req_repeat_req,
   input  logic [esp_pkg::SLOTIDX_W-1:0]      req_slot_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_granted,
   output logic [esp_pkg::SLOTIDX_W-1:0]      rsp_slot_out,
   output logic [esp_pkg::EFFECT_W-1:0]       rsp_effect_out,
   output logic [esp_pkg::FRAME_W-1:0]        rsp_frame_out,
   output logic [esp_pkg::PARTS_W-1:0]        rsp_parts_out,
   output logic                               rsp_playing_out,
   output logic                               rsp_looping_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [esp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [esp_pkg::LEN_W-1:0]          csr_data
);

   import esp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Length registers take a write on any cycle.
   assign csr_ready = 1'b1;

   esp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   esp_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_effect_type (req_effect_type),
      .req_repeat_req  (req_repeat_req),
      .req_slot_index  (req_slot_index),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_granted     (rsp_granted),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_effect_out  (rsp_effect_out),
      .rsp_frame_out   (rsp_frame_out),
      .rsp_parts_out   (rsp_parts_out),
      .rsp_playing_out (rsp_playing_out),
      .rsp_looping_out (rsp_looping_out)
   );

endmodule

[rtl/core/esp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module esp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/esp_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Reduces a 9-bit frame count modulo an 8-bit length, one bit per cycle.
// ----------------------------------------------------------------------------
module esp_mod (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [8:0] dividend,
   input  logic [7:0] divisor,
   output logic       done,
   output logic [7:0] rem
);

   localparam logic [3:0] STEPS = 4'd9;

   logic [8:0] num_ff;
   logic [8:0] rem_ff;
   logic [3:0] step_ff;
   logic       run_ff;
   logic       done_ff;
   logic [8:0] trial;
   logic [8:0] div9;

   // Restoring step: shift in the next dividend bit and subtract if it fits.
   assign trial = {rem_ff[7:0], num_ff[8]};
   assign div9  = {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= STEPS;
      end else if (run_ff) begin
         step_ff <= step_ff - 4'd1;
         if (step_ff == 4'd1) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[7:0], 1'b0};
         rem_ff <= (trial >= div9) ? (trial - div9) : trial;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff[7:0];

endmodule

[rtl/core/esp_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect slot pool datapath
// Slot memory, valid and busy flags, length registers, frame update logic,
// remainder unit, result staging and the response register.
// ----------------------------------------------------------------------------
module esp_dpath #(
   parameter int SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  esp_pkg::cmd_type                   cmd,
   output esp_pkg::sts_type                   sts,
   input  logic [esp_pkg::KIND_W-1:0]         req_kind,
   input  logic [esp_pkg::EFFECT_W-1:0]       req_effect_type,
   input  logic                               req_repeat_req,
   input  logic [esp_pkg::SLOTIDX_W-1:0]      req_slot_index,
   input  logic                               csr_valid,
   input  logic [esp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [esp_pkg::LEN_W-1:0]          csr_data,
   output logic                               rsp_granted,
   output logic [esp_pkg::SLOTIDX_W-1:0]      rsp_slot_out,
   output logic [esp_pkg::EFFECT_W-1:0]       rsp_effect_out,
   output logic [esp_pkg::FRAME_W-1:0]        rsp_frame_out,
   output logic [esp_pkg::PARTS_W-1:0]        rsp_parts_out,
   output logic                               rsp_playing_out,
   output logic                               rsp_looping_out
);

   import esp_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W:0]   SLOTS_C = (SLOT_W + 1)'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_C  = SLOT_W'(SLOTS - 1);

   // Captured request fields.
   logic [KIND_W-1:0]    kind_ff;
   logic [EFFECT_W-1:0]  eff_ff;
   logic                 rep_ff;
   logic [SLOTIDX_W-1:0] idx_ff;

   // Slot counter, last read address and flags.
   logic [SLOT_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] addr_ff;
   logic              rd_vld_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic [SLOTS-1:0]  busy_ff;
   logic [LEN_W-1:0]  len_ff [NUM_LEN];

   res_type res_ff;
   res_type rsp_ff;

   logic [SLOT_W-1:0]    rd_addr;
   logic                 rd_ok;
   logic [SLOT_BITS-1:0] ram_rdata;
   slot_type             ent;
   logic [LEN_W-1:0]     len_sel;
   logic [LEN_W-1:0]     cur_len;
   logic [8:0]           nxt;
   logic [8:0]           len9;
   logic                 act;
   logic                 need_mod;
   slot_type             tick_ent;
   slot_type             mod_ent;
   slot_type             slot_ent;
   slot_type             emit_ent;
   logic                 slot_cmd;
   logic                 in_pool;
   logic                 mod_done;
   logic [7:0]           mod_rem;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   slot_type             wr_ent;
   res_type              res_in;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         kind_ff <= req_kind;
         eff_ff  <= req_effect_type;
         rep_ff  <= req_repeat_req;
         idx_ff  <= req_slot_index;
      end
   end

   // Effect length registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEN; i++) begin
            len_ff[i] <= LEN_RESET[i];
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_LEN))) begin
         len_ff[csr_index] <= csr_data;
      end
   end

   // Slot counter used by the free-slot scan and the tick sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + SLOT_W'(1);
      end
   end

   // Read address and the valid flag of the entry being read.
   assign rd_addr = cmd.rd_req ? SLOT_W'(req_slot_index) : cnt_ff;
   assign rd_ok   = ({1'b0, rd_addr} < SLOTS_C);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         addr_ff   <= rd_addr;
         rd_vld_ff <= rd_ok && valid_ff[rd_addr];
      end
   end

   esp_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // An entry never written since reset reads as an all-zero slot.
   assign ent = rd_vld_ff ? slot_type'(ram_rdata) : '0;

   // Length of the effect held by the entry; zero counts as one frame.
   always_comb begin
      len_sel = 8'd1;
      if (ent.effect != '0) begin
         len_sel = len_ff[ent.effect - 3'd1];
      end
      cur_len = (len_sel == '0) ? 8'd1 : len_sel;
   end

   assign nxt      = {1'b0, ent.frame} + 9'd1;
   assign len9     = {1'b0, cur_len};
   assign act      = (ent.effect != '0) && ent.playing;
   assign need_mod = act && (ent.frame != '0) && (nxt > len9);

   // Frame timer update of one slot.
   always_comb begin
      tick_ent = ent;
      if (ent.frame == '0) begin
         tick_ent.parts = PART_TABLE[ent.effect];
         tick_ent.frame = (nxt == len9) ? '0 : nxt[7:0];
      end else if ((nxt == len9) && !ent.looping) begin
         tick_ent.effect  = '0;
         tick_ent.playing = 1'b0;
      end else begin
         tick_ent.frame = (nxt == len9) ? '0 : nxt[7:0];
      end
   end

   // Frame reduced after the slot's length was lowered to or below it.
   esp_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (nxt),
      .divisor  (cur_len),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      mod_ent       = ent;
      mod_ent.frame = mod_rem;
   end

   // Play, stop and query act on the addressed slot.
   assign in_pool  = (32'(idx_ff) < SLOTS);
   assign slot_cmd = (kind_ff == KIND_PLAY) || (kind_ff == KIND_STOP);

   always_comb begin
      slot_ent = ent;
      if (slot_cmd) begin
         slot_ent.playing = (kind_ff == KIND_PLAY);
      end
   end

   // A fresh slot taken by an emit.
   always_comb begin
      emit_ent         = '0;
      emit_ent.effect  = eff_ff;
      emit_ent.looping = rep_ff;
      emit_ent.playing = 1'b1;
   end

   // Write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_ent  = tick_ent;
      if (cmd.emit_wr) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_ent  = emit_ent;
      end else begin
         case (cmd.wr_op)
            WR_TICK: begin
               wr_en  = act;
               wr_ent = tick_ent;
            end
            WR_MOD: begin
               wr_en  = 1'b1;
               wr_ent = mod_ent;
            end
            WR_SLOT: begin
               wr_en  = in_pool && slot_cmd;
               wr_ent = slot_ent;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // Valid and busy flags follow every slot write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         busy_ff[wr_addr]  <= (wr_ent.effect != '0);
      end
   end

   // Result staging.
   always_comb begin
      res_in = res_ff;
      case (cmd.res_op)
         RES_ZERO: begin
            res_in = '0;
         end
         RES_EMIT: begin
            res_in.granted = 1'b1;
            res_in.slot    = SLOTIDX_W'(cnt_ff);
            res_in.entry   = emit_ent;
         end
         RES_SLOT: begin
            res_in.granted = 1'b0;
            res_in.slot    = idx_ff;
            res_in.entry   = in_pool ? slot_ent : '0;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.out_ld) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_granted     = rsp_ff.granted;
   assign rsp_slot_out    = rsp_ff.slot;
   assign rsp_effect_out  = rsp_ff.entry.effect;
   assign rsp_frame_out   = rsp_ff.entry.frame;
   assign rsp_parts_out   = rsp_ff.entry.parts;
   assign rsp_playing_out = rsp_ff.entry.playing;
   assign rsp_looping_out = rsp_ff.entry.looping;

   // Status back to the controller.
   assign sts.cnt_last = (cnt_ff == LAST_C);
   assign sts.cur_free = !busy_ff[cnt_ff];
   assign sts.need_mod = need_mod;
   assign sts.mod_done = mod_done;

endmodule

[rtl/core/esp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect slot pool controller
// Sequences the free-slot scan, the tick sweep, single slot accesses and
// the hand-over of each result to the response register.
// ----------------------------------------------------------------------------
module esp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [esp_pkg::KIND_W-1:0] req_kind,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  esp_pkg::sts_type           sts,
   output esp_pkg::cmd_type           cmd
);

   import esp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_TICK = 3'd2;
   localparam logic [2:0] S_TMOD = 3'd3;
   localparam logic [2:0] S_SLOT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       pend_ff;
   logic       pend_in;
   logic       last_ff;
   logic       last_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // The response register can take a beat when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               unique case (req_kind) inside
                  KIND_TICK: begin
                     cmd.cnt_clr = 1'b1;
                     pend_in     = 1'b0;
                     last_in     = 1'b0;
                     state_in    = S_TICK;
                  end
                  KIND_EMIT: begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = S_SCAN;
                  end
                  KIND_PLAY, KIND_STOP, KIND_QUERY: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_req = 1'b1;
                     state_in   = S_SLOT;
                  end
                  default: begin
                     cmd.res_op = RES_ZERO;
                     state_in   = S_DONE;
                  end
               endcase
            end
         end

         // Walk the busy flags for the lowest free slot.
         S_SCAN: begin
            if (sts.cur_free) begin
               cmd.emit_wr = 1'b1;
               cmd.res_op  = RES_EMIT;
               state_in    = S_DONE;
            end else if (sts.cnt_last) begin
               cmd.res_op = RES_ZERO;
               state_in   = S_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end

         // Read one slot per cycle, updating the last read, unless reducing.
         S_TICK: begin
            if (pend_ff && sts.need_mod) begin
               cmd.mod_start = 1'b1;
               state_in      = S_TMOD;
            end else begin
               if (pend_ff) begin
                  cmd.wr_op = WR_TICK;
               end
               if (!last_ff) begin
                  cmd.rd_en   = 1'b1;
                  cmd.cnt_inc = !sts.cnt_last;
                  pend_in     = 1'b1;
                  last_in     = sts.cnt_last;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     cmd.res_op = RES_ZERO;
                     state_in   = S_DONE;
                  end
               end
            end
         end

         // Wait for the reduced frame, then write it back.
         S_TMOD: begin
            if (sts.mod_done) begin
               cmd.wr_op = WR_MOD;
               pend_in   = 1'b0;
               state_in  = S_TICK;
            end
         end

         S_SLOT: begin
            cmd.wr_op  = WR_SLOT;
            cmd.res_op = RES_SLOT;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/esp_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect slot pool port checker
// Watches the request and response ports of the pool over time.
// ----------------------------------------------------------------------------
module esp_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_granted,
   input logic [esp_pkg::SLOTIDX_W-1:0] rsp_slot_out,
   input logic [esp_pkg::EFFECT_W-1:0]  rsp_effect_out,
   input logic [esp_pkg::FRAME_W-1:0]   rsp_frame_out,
   input logic [esp_pkg::PARTS_W-1:0]   rsp_parts_out,
   input logic                          rsp_playing_out,
   input logic                          rsp_looping_out
);

   // A stalled response beat stays presented and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted)
         && $stable(rsp_slot_out) && $stable(rsp_effect_out)
         && $stable(rsp_frame_out) && $stable(rsp_parts_out)
         && $stable(rsp_playing_out) && $stable(rsp_looping_out))
      else $error("stalled response beat changed");

   // One request at a time: a taken request blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in progress");

   // A granted slot starts playing from frame zero with no parts.
   a_grant_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_playing_out && (rsp_frame_out == 8'd0)
         && (rsp_parts_out == 6'd0))
      else $error("granted slot not freshly started");

   // Reported part counts stay within the table and frames below the largest length.
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parts_out <= 6'd40) && (rsp_frame_out <= 8'd254))
      else $error("reported slot out of range");

endmodule

bind effect_slot_pool_timers esp_chk u_chk (.*);

[dv/tb_effect_slot_pool_timers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the effect slot pool with frame timers
// Drives request beats through the valid/stall handshake, keeps its own model
// of the slot pool and of the effect lengths, and checks every response beat
// field by field against the oldest predicted beat. A short directed part
// covers reset state, unknown kinds, allocation, freeing, one-frame and
// zero lengths and lowered lengths; random phases with different length
// settings and idle rates follow.
// ----------------------------------------------------------------------------
module tb_effect_slot_pool_timers;
   import esp_pkg::*;

   localparam int POOL_SLOTS    = 16;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int TAIL_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTED  = 10;

   // Length register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LEN_EFFECT_1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_EFFECT_2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_EFFECT_3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_EFFECT_4 = 3'd3;

   // Request kinds the block ignores.
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind        = '0;
   logic [EFFECT_W-1:0]  req_effect_type = '0;
   logic                 req_repeat_req  = 1'b0;
   logic [SLOTIDX_W-1:0] req_slot_index  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic                 rsp_granted;
   logic [SLOTIDX_W-1:0] rsp_slot_out;
   logic [EFFECT_W-1:0]  rsp_effect_out;
   logic [FRAME_W-1:0]   rsp_frame_out;
   logic [PARTS_W-1:0]   rsp_parts_out;
   logic                 rsp_playing_out;
   logic                 rsp_looping_out;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [LEN_W-1:0]     csr_data        = '0;

   // Model of the pool and of the length registers.
   logic [EFFECT_W-1:0] pool_effect [POOL_SLOTS] = '{default: '0};
   logic [FRAME_W-1:0]  pool_frame  [POOL_SLOTS] = '{default: '0};
   logic [PARTS_W-1:0]  pool_parts  [POOL_SLOTS] = '{default: '0};
   logic                pool_loop   [POOL_SLOTS] = '{default: 1'b0};
   logic                pool_play   [POOL_SLOTS] = '{default: 1'b0};
   logic [LEN_W-1:0]    frame_len   [NUM_LEN];

   res_type     rsp_expected [$];
   int          idle_pct    = 21;
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   effect_slot_pool_timers #(
      .SLOTS(POOL_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_effect_type(req_effect_type),
      .req_repeat_req (req_repeat_req),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_effect_out (rsp_effect_out),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_parts_out  (rsp_parts_out),
      .rsp_playing_out(rsp_playing_out),
      .rsp_looping_out(rsp_looping_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Frames in one play of an effect; zero or no length counts as one frame.
   function automatic int unsigned frames_of(input logic [EFFECT_W-1:0] eff);
      int unsigned n;
      if (eff == '0) return 1;
      n = 32'(frame_len[eff - 3'd1]);
      return (n == 0) ? 1 : n;
   endfunction

   // Snapshot of one slot as the block reports it.
   function automatic res_type slot_report(input logic granted,
                                           input logic [SLOTIDX_W-1:0] idx);
      res_type r;
      r = '0;
      r.granted = granted;
      r.slot    = idx;
      if (idx < POOL_SLOTS) begin
         r.entry.effect  = pool_effect[idx];
         r.entry.frame   = pool_frame[idx];
         r.entry.parts   = pool_parts[idx];
         r.entry.looping = pool_loop[idx];
         r.entry.playing = pool_play[idx];
      end
      return r;
   endfunction

   // Applies one request to the pool model and returns the response beat.
   function automatic res_type predict_pool(input logic [KIND_W-1:0] kind,
                                            input logic [EFFECT_W-1:0] eff,
                                            input logic rep,
                                            input logic [SLOTIDX_W-1:0] idx);
      int unsigned          len;
      int unsigned          f;
      int                   free_slot;
      logic [SLOTIDX_W-1:0] sel;
      free_slot = -1;
      case (kind)
         KIND_TICK: begin
            // Sweep in slot order; only busy, playing slots move.
            for (int s = 0; s < POOL_SLOTS; s++) begin
               sel = SLOTIDX_W'(s);
               if (pool_effect[sel] != '0 && pool_play[sel]) begin
                  len = frames_of(pool_effect[sel]);
                  f   = 32'(pool_frame[sel]);
                  if (f == 0) begin
                     pool_parts[sel] = PART_TABLE[pool_effect[sel]];
                     pool_frame[sel] = FRAME_W'((f + 1) % len);
                  end else if (f == len - 1 && !pool_loop[sel]) begin
                     pool_play[sel]   = 1'b0;
                     pool_effect[sel] = '0;
                  end else begin
                     pool_frame[sel] = FRAME_W'((f + 1) % len);
                  end
               end
            end
            return '0;
         end
         KIND_EMIT: begin
            for (int s = POOL_SLOTS - 1; s >= 0; s--)
               if (pool_effect[SLOTIDX_W'(s)] == '0) free_slot = s;
            if (free_slot < 0) return '0;
            sel = SLOTIDX_W'(free_slot);
            pool_effect[sel] = eff;
            pool_frame[sel]  = '0;
            pool_parts[sel]  = '0;
            pool_loop[sel]   = rep;
            pool_play[sel]   = 1'b1;
            return slot_report(1'b1, sel);
         end
         KIND_PLAY, KIND_STOP: begin
            if (idx < POOL_SLOTS) pool_play[idx] = (kind == KIND_PLAY);
            return slot_report(1'b0, idx);
         end
         KIND_QUERY: return slot_report(1'b0, idx);
         default: return '0;
      endcase
   endfunction

   // Sends one request beat with random idle cycles in front of it. Valid is
   // left high after acceptance so that back-to-back beats need no toggle.
   task automatic send_command(input logic [KIND_W-1:0] kind,
                               input logic [EFFECT_W-1:0] eff,
                               input logic rep,
                               input logic [SLOTIDX_W-1:0] idx);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_effect_type <= eff;
      req_repeat_req  <= rep;
      req_slot_index  <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rsp_expected.push_back(predict_pool(kind, eff, rep, idx));
   endtask

   // Holds off the sender until every predicted beat has come back and the
   // block has settled, so that registers may be written.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [CSR_IDX_W-1:0] reg_idx,
                               input logic [LEN_W-1:0] frames);
      csr_valid <= 1'b1;
      csr_index <= reg_idx;
      csr_data  <= frames;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (reg_idx < NUM_LEN) frame_len[reg_idx] = frames;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random request, mostly well formed, with a few ignored kinds as noise.
   task automatic send_random_command(input int emit_weight);
      int unsigned  roll;
      int unsigned  pick;
      logic [KIND_W-1:0]   kind;
      logic [EFFECT_W-1:0] eff;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      eff  = EFFECT_W'($urandom_range(0, 7));
      if (roll < 4) begin
         kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      end else if (roll < 4 + emit_weight) begin
         kind = KIND_EMIT;
         eff  = ($urandom_range(0, 15) == 0) ? 3'd0 : EFFECT_W'($urandom_range(1, 7));
      end else if (pick < 5) begin
         kind = KIND_TICK;
      end else if (pick == 5) begin
         kind = KIND_PLAY;
      end else if (pick == 6) begin
         kind = KIND_STOP;
      end else begin
         kind = KIND_QUERY;
      end
      send_command(kind, eff, 1'($urandom_range(0, 1)),
                   SLOTIDX_W'($urandom_range(0, POOL_SLOTS - 1)));
   endtask

   // Reset state, ignored kinds and a tick over an empty pool.
   task automatic test_idle_state();
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd7, 1'b1, 4'd15);
      send_command(KIND_UNUSED_HI, 3'd7, 1'b1, 4'd15);
      send_command(KIND_UNUSED_LO, 3'd0, 1'b0, 4'd0);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
   endtask

   // Allocation, type-0 emits, timer freeing, one-frame and zero lengths,
   // stop and play.
   task automatic test_emit_and_timers();
      drain_responses();
      write_length(REG_LEN_EFFECT_1, 8'd2);
      write_length(REG_LEN_EFFECT_2, 8'd1);
      write_length(REG_LEN_EFFECT_3, 8'd0);
      send_command(KIND_EMIT, 3'd1, 1'b0, 4'd9);
      send_command(KIND_EMIT, 3'd2, 1'b0, 4'd0);
      // Type 0 takes a slot but leaves it free for the next emit.
      send_command(KIND_EMIT, 3'd0, 1'b1, 4'd0);
      send_command(KIND_EMIT, 3'd3, 1'b1, 4'd0);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd1);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd2);
      send_command(KIND_STOP, 3'd0, 1'b0, 4'd1);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd1);
      send_command(KIND_PLAY, 3'd0, 1'b0, 4'd1);
   endtask

   // A length lowered under a running slot: the frame wraps, then expires.
   task automatic test_lowered_length();
      send_command(KIND_EMIT, 3'd4, 1'b0, 4'd0);
      repeat (4) send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      drain_responses();
      write_length(REG_LEN_EFFECT_4, 8'd3);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd0);
      send_command(KIND_TICK, 3'd0, 1'b0, 4'd0);
      send_command(KIND_QUERY, 3'd0, 1'b0, 4'd0);
   endtask

   // Random traffic in phases, each with its own lengths and idle rate.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         for (int r = 0; r < NUM_LEN; r++) begin
            case (phase)
               0: write_length(CSR_IDX_W'(r), LEN_W'($urandom_range(1, 6)));
               1: write_length(CSR_IDX_W'(r), LEN_W'($urandom_range(0, 12)));
               // Extremes: shortest, longest and zero.
               2: write_length(CSR_IDX_W'(r),
                               (r % 3 == 0) ? 8'd1 : (r % 3 == 1) ? 8'd255 : 8'd0);
               default: write_length(CSR_IDX_W'(r), ($urandom_range(0, 7) == 0) ?
                                        LEN_W'($urandom_range(0, 255)) :
                                        LEN_W'($urandom_range(1, 6)));
            endcase
         end
         // The second phase runs without any idling and fills the pool.
         idle_pct = (phase == 1) ? 0 : 21;
         repeat (100) send_random_command((phase == 1) ? 45 : 22);
      end
      idle_pct = 21;
   endtask

   // The receiver stalls at random in step with the sender's idle rate.
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < idle_pct);

   // Response checker: each accepted beat against the oldest prediction.
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("Unexpected response beat at cycle %0d: slot=%0d", cycle_count,
                        rsp_slot_out);
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_granted !== want.granted || rsp_slot_out !== want.slot ||
                rsp_effect_out !== want.entry.effect ||
                rsp_frame_out !== want.entry.frame ||
                rsp_parts_out !== want.entry.parts ||
                rsp_playing_out !== want.entry.playing ||
                rsp_looping_out !== want.entry.looping) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED)
                  $display({"Mismatch at cycle %0d: expected g=%0d slot=%0d eff=%0d ",
                            "frame=%0d parts=%0d play=%0d loop=%0d, got g=%0d slot=%0d ",
                            "eff=%0d frame=%0d parts=%0d play=%0d loop=%0d"},
                           cycle_count, want.granted, want.slot, want.entry.effect,
                           want.entry.frame, want.entry.parts, want.entry.playing,
                           want.entry.looping, rsp_granted, rsp_slot_out, rsp_effect_out,
                           rsp_frame_out, rsp_parts_out, rsp_playing_out, rsp_looping_out);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      foreach (frame_len[i]) frame_len[i] = LEN_RESET[i];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_state();
      test_emit_and_timers();
      test_lowered_length();
      test_random_traffic();

      // Wait for the last beats, then give the block time to show strays.
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
